// File: sv/lts_pkg.sv
// shared types, constants and keyword tables of the lexical token scanner
package lts_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned KindW   = 5;
  localparam int unsigned KwIdxW  = 3;
  localparam int unsigned LenW    = 8;
  localparam int unsigned PosW    = 3;
  localparam int unsigned NumKw   = 7;
  localparam int unsigned MaxLength = 255;
  localparam logic [LenW-1:0] LenCap = (MaxLength < 255) ? LenW'(MaxLength) : LenW'(255);
  localparam logic [PosW-1:0] PosMax = '1;

  typedef enum logic [KindW-1:0] {
    TK_KEYWORD = 5'd0,
    TK_IDENT   = 5'd1,
    TK_DEC     = 5'd2,
    TK_OCT     = 5'd3,
    TK_HEX     = 5'd4,
    TK_BAD_OCT = 5'd5,
    TK_BAD_HEX = 5'd6,
    TK_PLUS    = 5'd7,
    TK_MINUS   = 5'd8,
    TK_STAR    = 5'd9,
    TK_SLASH   = 5'd10,
    TK_GT      = 5'd11,
    TK_LT      = 5'd12,
    TK_EQ      = 5'd13,
    TK_GE      = 5'd14,
    TK_LE      = 5'd15,
    TK_NEQ     = 5'd16,
    TK_LPAREN  = 5'd17,
    TK_RPAREN  = 5'd18,
    TK_SEMI    = 5'd19,
    TK_UNKNOWN = 5'd20
  } token_kind_e;

  typedef enum logic [10:0] {
    M_IDLE   = 11'b000_0000_0001,
    M_WORD   = 11'b000_0000_0010,
    M_ZERO   = 11'b000_0000_0100,
    M_HEXPRE = 11'b000_0000_1000,
    M_HEX    = 11'b000_0001_0000,
    M_BADHEX = 11'b000_0010_0000,
    M_OCT    = 11'b000_0100_0000,
    M_BADOCT = 11'b000_1000_0000,
    M_DEC    = 11'b001_0000_0000,
    M_LT     = 11'b010_0000_0000,
    M_GT     = 11'b100_0000_0000
  } scan_mode_e;

  typedef struct packed {
    token_kind_e        kind;
    logic [KwIdxW-1:0]  kw;
    logic [LenW-1:0]    len;
    logic               last;
  } result_t;

  // keyword text, zero padded
  localparam logic [CharW-1:0] KwText [NumKw][8] = '{
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00},
    '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [PosW-1:0] KwLen [NumKw] = '{
    3'd5, 3'd2, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3
  };

  function automatic logic [NumKw-1:0] kw_filter(logic [NumKw-1:0] cand,
                                                 logic [PosW-1:0] pos,
                                                 logic [CharW-1:0] c);
    logic [NumKw-1:0] keep;
    keep = '0;
    for (int i = 0; i < NumKw; i++) begin
      keep[i] = cand[i] && (pos < KwLen[i]) && (KwText[i][pos] == c);
    end
    return keep;
  endfunction

  function automatic logic is_digit(logic [CharW-1:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_letter(logic [CharW-1:0] c);
    return c inside {["A":"Z"], ["a":"z"]};
  endfunction

  function automatic logic is_hexdig(logic [CharW-1:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  function automatic logic is_badhex(logic [CharW-1:0] c);
    return c inside {["g":"z"], ["G":"Z"]};
  endfunction

  function automatic logic is_octdig(logic [CharW-1:0] c);
    return c inside {["0":"7"]};
  endfunction

endpackage

// File: sv/lts_in_if.sv
// request channel carrying characters and end-of-input commands
interface lts_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [lts_pkg::CharW-1:0] ch;

  modport source (output valid, output cmd, output ch, input ready);
  modport sink   (input valid, input cmd, input ch, output ready);
endinterface

// File: sv/lts_out_if.sv
// request channel carrying classified tokens
interface lts_out_if;
  logic                       valid;
  logic                       ready;
  logic [lts_pkg::KindW-1:0]  token_kind;
  logic [lts_pkg::KwIdxW-1:0] keyword_index;
  logic [lts_pkg::LenW-1:0]   token_length;
  logic                       last;

  modport source (output valid, output token_kind, output keyword_index,
                  output token_length, output last, input ready);
  modport sink   (input valid, input token_kind, input keyword_index,
                  input token_length, input last, output ready);
endinterface

// File: sv/lexical_token_scanner_top.sv
// lexical token scanner: one-pass character classifier with a four-entry result queue
// a token closed by a request is written into the result queue when the request is accepted
// throughput: one character request per cycle while the queue has two free entries;
//   a request giving two tokens is drained as two output transfers
// reset: scanner returns to idle between tokens, candidates, position and length cleared,
//   result queue emptied
module lexical_token_scanner_top (
  input  logic clk_i,
  input  logic rst_ni,
  lts_in_if.sink    in_i,
  lts_out_if.source out_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  lts_pkg::scan_mode_e               mode_q, mode_d;
  logic [lts_pkg::NumKw-1:0]         cand_q, cand_d;
  logic [lts_pkg::PosW-1:0]          pos_q, pos_d;
  logic [lts_pkg::LenW-1:0]          len_q, len_d;

  lts_pkg::result_t                  queue_q [QDepth];
  logic [QPtrW-1:0]                  wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]                    count_q;

  logic                              in_fire, out_fire;
  logic [lts_pkg::CharW-1:0]         c;

  // close of the pending token
  logic                              cl_v;
  lts_pkg::token_kind_e              cl_kind;
  logic [lts_pkg::KwIdxW-1:0]        cl_kw;
  logic [lts_pkg::LenW-1:0]          cl_len;

  // fresh start on the current character
  lts_pkg::scan_mode_e               st_mode;
  logic [lts_pkg::NumKw-1:0]         st_cand;
  logic [lts_pkg::PosW-1:0]          st_pos;
  logic [lts_pkg::LenW-1:0]          st_len;
  logic                              st_v;
  lts_pkg::token_kind_e              st_kind;

  // extension of the pending token
  logic                              ex_ok;
  lts_pkg::scan_mode_e               ex_mode;
  logic [lts_pkg::NumKw-1:0]         ex_cand;
  logic [lts_pkg::PosW-1:0]          ex_pos;
  logic [lts_pkg::LenW-1:0]          ex_len;
  logic                              ex_v;
  lts_pkg::token_kind_e              ex_kind;

  lts_pkg::result_t                  r0, r1;
  logic                              r0_v, r1_v;
  logic [QPtrW:0]                    push_n;

  logic [lts_pkg::LenW-1:0]          len_grow;

  assign c        = in_i.ch;
  assign in_i.ready = (count_q <= (QPtrW+1)'(QDepth - 2));
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign len_grow = (len_q < lts_pkg::LenCap) ? len_q + 1'b1 : len_q;

  always_comb begin
    cl_v    = (mode_q != lts_pkg::M_IDLE);
    cl_kind = lts_pkg::TK_IDENT;
    cl_kw   = '0;
    cl_len  = len_q;
    case (mode_q)
      lts_pkg::M_WORD: begin
        cl_kind = lts_pkg::TK_IDENT;
        for (int i = lts_pkg::NumKw - 1; i >= 0; i--) begin
          if (cand_q[i] && (lts_pkg::KwLen[i] == pos_q)) begin
            cl_kind = lts_pkg::TK_KEYWORD;
            cl_kw   = lts_pkg::KwIdxW'(i);
          end
        end
      end
      lts_pkg::M_ZERO, lts_pkg::M_DEC:   cl_kind = lts_pkg::TK_DEC;
      lts_pkg::M_OCT:                    cl_kind = lts_pkg::TK_OCT;
      lts_pkg::M_HEXPRE, lts_pkg::M_HEX: cl_kind = lts_pkg::TK_HEX;
      lts_pkg::M_BADOCT:                 cl_kind = lts_pkg::TK_BAD_OCT;
      lts_pkg::M_BADHEX:                 cl_kind = lts_pkg::TK_BAD_HEX;
      lts_pkg::M_GT: begin
        cl_kind = lts_pkg::TK_GT;
        cl_len  = lts_pkg::LenW'(1);
      end
      lts_pkg::M_LT: begin
        cl_kind = lts_pkg::TK_LT;
        cl_len  = lts_pkg::LenW'(1);
      end
      default: cl_v = 1'b0;
    endcase
  end

  always_comb begin
    st_mode = lts_pkg::M_IDLE;
    st_cand = '0;
    st_pos  = '0;
    st_len  = '0;
    st_v    = 1'b0;
    st_kind = lts_pkg::TK_UNKNOWN;
    if (c == " " || c == 8'h0a) begin
      st_mode = lts_pkg::M_IDLE;
    end else if (lts_pkg::is_letter(c)) begin
      st_mode = lts_pkg::M_WORD;
      st_cand = lts_pkg::kw_filter('1, '0, c);
      st_pos  = lts_pkg::PosW'(1);
      st_len  = lts_pkg::LenW'(1);
    end else if (lts_pkg::is_digit(c)) begin
      st_mode = (c == "0") ? lts_pkg::M_ZERO : lts_pkg::M_DEC;
      st_len  = lts_pkg::LenW'(1);
    end else begin
      case (c)
        "<": begin
          st_mode = lts_pkg::M_LT;
          st_len  = lts_pkg::LenW'(1);
        end
        ">": begin
          st_mode = lts_pkg::M_GT;
          st_len  = lts_pkg::LenW'(1);
        end
        "+":     begin st_v = 1'b1; st_kind = lts_pkg::TK_PLUS;   end
        "-":     begin st_v = 1'b1; st_kind = lts_pkg::TK_MINUS;  end
        "*":     begin st_v = 1'b1; st_kind = lts_pkg::TK_STAR;   end
        "/":     begin st_v = 1'b1; st_kind = lts_pkg::TK_SLASH;  end
        "=":     begin st_v = 1'b1; st_kind = lts_pkg::TK_EQ;     end
        "(":     begin st_v = 1'b1; st_kind = lts_pkg::TK_LPAREN; end
        ")":     begin st_v = 1'b1; st_kind = lts_pkg::TK_RPAREN; end
        ";":     begin st_v = 1'b1; st_kind = lts_pkg::TK_SEMI;   end
        default: begin st_v = 1'b1; st_kind = lts_pkg::TK_UNKNOWN; end
      endcase
    end
  end

  always_comb begin
    ex_ok   = 1'b0;
    ex_mode = mode_q;
    ex_cand = cand_q;
    ex_pos  = pos_q;
    ex_len  = len_grow;
    ex_v    = 1'b0;
    ex_kind = lts_pkg::TK_LE;
    case (mode_q)
      lts_pkg::M_WORD: begin
        if (lts_pkg::is_letter(c) || lts_pkg::is_digit(c)) begin
          ex_ok   = 1'b1;
          ex_cand = lts_pkg::kw_filter(cand_q, pos_q, c);
          ex_pos  = (pos_q == lts_pkg::PosMax) ? pos_q : pos_q + 1'b1;
        end
      end
      lts_pkg::M_ZERO: begin
        ex_ok = 1'b1;
        if (c == "x" || c == "X")             ex_mode = lts_pkg::M_HEXPRE;
        else if (lts_pkg::is_octdig(c))        ex_mode = lts_pkg::M_OCT;
        else if (c == "8" || c == "9")        ex_mode = lts_pkg::M_BADOCT;
        else                                   ex_ok   = 1'b0;
      end
      lts_pkg::M_OCT: begin
        ex_ok = 1'b1;
        if (lts_pkg::is_octdig(c))             ex_mode = lts_pkg::M_OCT;
        else if (c == "8" || c == "9")        ex_mode = lts_pkg::M_BADOCT;
        else                                   ex_ok   = 1'b0;
      end
      lts_pkg::M_BADOCT, lts_pkg::M_DEC: begin
        ex_ok = lts_pkg::is_digit(c);
      end
      lts_pkg::M_HEXPRE, lts_pkg::M_HEX: begin
        ex_ok = 1'b1;
        if (lts_pkg::is_hexdig(c))             ex_mode = lts_pkg::M_HEX;
        else if (lts_pkg::is_badhex(c))        ex_mode = lts_pkg::M_BADHEX;
        else                                   ex_ok   = 1'b0;
      end
      lts_pkg::M_BADHEX: begin
        ex_ok = lts_pkg::is_letter(c) || lts_pkg::is_digit(c);
      end
      lts_pkg::M_LT: begin
        ex_mode = lts_pkg::M_IDLE;
        ex_len  = '0;
        if (c == "=") begin
          ex_ok   = 1'b1;
          ex_v    = 1'b1;
          ex_kind = lts_pkg::TK_LE;
        end else if (c == ">") begin
          ex_ok   = 1'b1;
          ex_v    = 1'b1;
          ex_kind = lts_pkg::TK_NEQ;
        end
      end
      lts_pkg::M_GT: begin
        ex_mode = lts_pkg::M_IDLE;
        ex_len  = '0;
        if (c == "=") begin
          ex_ok   = 1'b1;
          ex_v    = 1'b1;
          ex_kind = lts_pkg::TK_GE;
        end
      end
      default: ex_ok = 1'b0;
    endcase
  end

  // next state and the results of this request
  always_comb begin
    mode_d = mode_q;
    cand_d = cand_q;
    pos_d  = pos_q;
    len_d  = len_q;
    r0_v   = 1'b0;
    r1_v   = 1'b0;
    r0     = '{kind: cl_kind, kw: cl_kw, len: cl_len, last: 1'b0};
    r1     = '{kind: st_kind, kw: '0, len: lts_pkg::LenW'(1), last: 1'b1};
    if (in_i.cmd) begin
      r0_v   = cl_v;
      mode_d = lts_pkg::M_IDLE;
      cand_d = '0;
      pos_d  = '0;
      len_d  = '0;
    end else if (mode_q == lts_pkg::M_IDLE) begin
      r0_v   = st_v;
      r0     = r1;
      mode_d = st_mode;
      cand_d = st_cand;
      pos_d  = st_pos;
      len_d  = st_len;
    end else if (ex_ok) begin
      r0_v   = ex_v;
      r0     = '{kind: ex_kind, kw: '0, len: lts_pkg::LenW'(2), last: 1'b0};
      mode_d = ex_mode;
      cand_d = ex_cand;
      pos_d  = ex_pos;
      len_d  = ex_len;
    end else begin
      r0_v   = cl_v;
      r1_v   = st_v;
      mode_d = st_mode;
      cand_d = st_cand;
      pos_d  = st_pos;
      len_d  = st_len;
    end
    r0.last = !r1_v;
    push_n  = (QPtrW+1)'(r0_v) + (QPtrW+1)'(r1_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lts_pkg::M_IDLE;
      cand_q <= '0;
      pos_q  <= '0;
      len_q  <= '0;
    end else if (in_fire) begin
      mode_q <= mode_d;
      cand_q <= cand_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
    end
  end

  // result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + push_n[QPtrW-1:0];
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (in_fire ? push_n : '0) - (QPtrW+1)'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && r0_v) begin
      queue_q[wr_ptr_q] <= r0;
    end
    if (in_fire && r1_v) begin
      queue_q[wr_ptr_q + 1'b1] <= r1;
    end
  end

  assign out_o.valid         = (count_q != '0);
  assign out_o.token_kind    = queue_q[rd_ptr_q].kind;
  assign out_o.keyword_index = queue_q[rd_ptr_q].kw;
  assign out_o.token_length  = queue_q[rd_ptr_q].len;
  assign out_o.last          = queue_q[rd_ptr_q].last;

endmodule

// File: test/lexical_token_scanner_top_test.sv
// testbench of the lexical token scanner: random token streams checked against a scoreboard
`timescale 1ns / 1ps

module lexical_token_scanner_top_test;
  import lts_pkg::*;

  localparam int unsigned ItemTarget    = 1700;
  localparam int unsigned PhaseItems    = 200;
  localparam int unsigned HoldCycles    = 120;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned ReportLimit   = 40;

  localparam string Letters   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string Digits    = "0123456789";
  localparam string Alnum     = {Letters, Digits};
  localparam string Octal     = "01234567";
  localparam string HexDigits = "0123456789abcdefABCDEF";
  localparam string BadHex    = "ghijklmnopqrstuvwxyzGHIJKLMNOPQRSTUVWXYZ";
  localparam string Strays    = "\t\015!#$%&_.,:?@[]{}~";

  class token_scoreboard;
    scan_mode_e       mode;
    logic [NumKw-1:0] cand;
    logic [2:0]       pos;
    logic [LenW-1:0]  span;
    result_t          step_tokens[$];
    result_t          tokens_due[$];
    int unsigned      err_count;
    string            kw_words[NumKw];

    function new();
      kw_words = '{"while", "do", "if", "then", "else", "begin", "end"};
      err_count = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      mode = M_IDLE;
      cand = '0;
      pos  = '0;
      span = '0;
    endfunction

    function bit digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit letter_ch(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit hex_ch(logic [7:0] c);
      return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function bit bad_hex_ch(logic [7:0] c);
      return (c >= "g" && c <= "z") || (c >= "G" && c <= "Z");
    endfunction

    function bit octal_ch(logic [7:0] c);
      return c >= "0" && c <= "7";
    endfunction

    function void add_token(token_kind_e k, logic [KwIdxW-1:0] kw, logic [LenW-1:0] l);
      result_t r;
      r.kind = k;
      r.kw   = kw;
      r.len  = l;
      r.last = 1'b0;
      step_tokens.insert(step_tokens.size(), r);
    endfunction

    function void lengthen();
      if (span < LenCap) span++;
    endfunction

    function void match_keywords(logic [7:0] c);
      logic [NumKw-1:0] keep;
      keep = '0;
      for (int i = 0; i < NumKw; i++) begin
        if (cand[i] && pos < kw_words[i].len() && kw_words[i][pos] == c) keep[i] = 1'b1;
      end
      cand = keep;
      if (pos != 3'd7) pos++;
    endfunction

    function void close_pending();
      bit found;
      found = 1'b0;
      case (mode)
        M_WORD: begin
          for (int i = 0; i < NumKw; i++) begin
            if (!found && cand[i] && kw_words[i].len() == pos) begin
              add_token(TK_KEYWORD, 3'(i), span);
              found = 1'b1;
            end
          end
          if (!found) add_token(TK_IDENT, '0, span);
        end
        M_ZERO, M_DEC: add_token(TK_DEC, '0, span);
        M_OCT: add_token(TK_OCT, '0, span);
        M_HEXPRE, M_HEX: add_token(TK_HEX, '0, span);
        M_BADOCT: add_token(TK_BAD_OCT, '0, span);
        M_BADHEX: add_token(TK_BAD_HEX, '0, span);
        M_GT: add_token(TK_GT, '0, 8'd1);
        M_LT: add_token(TK_LT, '0, 8'd1);
        default: ;
      endcase
      clear_scan();
    endfunction

    function void begin_token(logic [7:0] c);
      if (c == " " || c == "\n") return;
      if (letter_ch(c)) begin
        mode = M_WORD;
        cand = '1;
        pos  = '0;
        match_keywords(c);
        span = 8'd1;
      end else if (digit_ch(c)) begin
        if (c == "0") mode = M_ZERO;
        else mode = M_DEC;
        span = 8'd1;
      end else begin
        case (c)
          "<": begin
            mode = M_LT;
            span = 8'd1;
          end
          ">": begin
            mode = M_GT;
            span = 8'd1;
          end
          "+": add_token(TK_PLUS, '0, 8'd1);
          "-": add_token(TK_MINUS, '0, 8'd1);
          "*": add_token(TK_STAR, '0, 8'd1);
          "/": add_token(TK_SLASH, '0, 8'd1);
          "=": add_token(TK_EQ, '0, 8'd1);
          "(": add_token(TK_LPAREN, '0, 8'd1);
          ")": add_token(TK_RPAREN, '0, 8'd1);
          ";": add_token(TK_SEMI, '0, 8'd1);
          default: add_token(TK_UNKNOWN, '0, 8'd1);
        endcase
      end
    endfunction

    function bit extend_pending(logic [7:0] c);
      scan_mode_e nxt;
      nxt = M_IDLE;
      case (mode)
        M_WORD: begin
          if (!(letter_ch(c) || digit_ch(c))) return 1'b0;
          match_keywords(c);
          lengthen();
          return 1'b1;
        end
        M_ZERO: begin
          if (c == "x" || c == "X") nxt = M_HEXPRE;
          else if (octal_ch(c)) nxt = M_OCT;
          else if (c == "8" || c == "9") nxt = M_BADOCT;
        end
        M_OCT: begin
          if (octal_ch(c)) nxt = M_OCT;
          else if (c == "8" || c == "9") nxt = M_BADOCT;
        end
        M_BADOCT, M_DEC: begin
          if (digit_ch(c)) nxt = mode;
        end
        M_HEXPRE, M_HEX: begin
          if (hex_ch(c)) nxt = M_HEX;
          else if (bad_hex_ch(c)) nxt = M_BADHEX;
        end
        M_BADHEX: begin
          if (letter_ch(c) || digit_ch(c)) nxt = M_BADHEX;
        end
        M_LT: begin
          if (c == "=") add_token(TK_LE, '0, 8'd2);
          else if (c == ">") add_token(TK_NEQ, '0, 8'd2);
          else return 1'b0;
          clear_scan();
          return 1'b1;
        end
        M_GT: begin
          if (c != "=") return 1'b0;
          add_token(TK_GE, '0, 8'd2);
          clear_scan();
          return 1'b1;
        end
        default: return 1'b0;
      endcase
      if (nxt == M_IDLE) return 1'b0;
      mode = nxt;
      lengthen();
      return 1'b1;
    endfunction

    function void note_request(logic cmd, logic [7:0] c);
      step_tokens.delete();
      if (cmd) close_pending();
      else if (mode == M_IDLE) begin_token(c);
      else if (!extend_pending(c)) begin
        close_pending();
        begin_token(c);
      end
      if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
    endfunction

    function void compare_field(string field, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
        err_count++;
        if (err_count <= ReportLimit)
          $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
      end
    endfunction

    function void check_token(logic [KindW-1:0] kind, logic [KwIdxW-1:0] kw,
                              logic [LenW-1:0] len, logic last);
      result_t want;
      if (tokens_due.size() == 0) begin
        err_count++;
        if (err_count <= ReportLimit)
          $display("%0t: token with none expected, kind %0d keyword %0d length %0d last %0d",
                   $time, kind, kw, len, last);
        return;
      end
      want = tokens_due.pop_front();
      compare_field("token_kind", want.kind, kind);
      compare_field("keyword_index", want.kw, kw);
      compare_field("token_length", want.len, len);
      compare_field("last", want.last, last);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lts_in_if  in_ch ();
  lts_out_if out_ch ();

  lexical_token_scanner_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  token_scoreboard sb = new();

  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int unsigned rx_hold_req;
  int unsigned items_sent;
  int unsigned idle_cycles;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic string one_char(logic [7:0] c);
    string t;
    t = " ";
    t.putc(0, c);
    return t;
  endfunction

  function automatic string rand_run(string set, int unsigned n);
    string s;
    s = "";
    repeat (n) s = {s, one_char(set[$urandom_range(0, set.len() - 1)])};
    return s;
  endfunction

  function automatic string random_word();
    string s;
    string kw;
    kw = sb.kw_words[$urandom_range(0, NumKw - 1)];
    case ($urandom_range(0, 15))
      0, 1: s = kw;
      2: s = kw.substr(0, kw.len() - 2);
      3: s = {kw, rand_run(Alnum, $urandom_range(1, 3))};
      4: s = {rand_run(Letters, 1), rand_run(Alnum, $urandom_range(0, 6))};
      5: s = {rand_run("123456789", 1), rand_run(Digits, $urandom_range(0, 4))};
      6: s = {"0", rand_run(Octal, $urandom_range(0, 4))};
      7: s = {"0", rand_run(Octal, $urandom_range(0, 2)), rand_run("89", 1),
               rand_run(Digits, $urandom_range(0, 3))};
      8: s = {"0", rand_run("xX", 1), rand_run(HexDigits, $urandom_range(0, 4))};
      9: s = {"0", rand_run("xX", 1), rand_run(HexDigits, $urandom_range(0, 2)),
               rand_run(BadHex, 1), rand_run(Alnum, $urandom_range(0, 3))};
      10: s = {rand_run("<>", 1), rand_run("<>=", $urandom_range(0, 1))};
      11: s = rand_run("+-*/=();", $urandom_range(1, 3));
      12: s = {rand_run(Digits, $urandom_range(1, 3)), rand_run(Letters, $urandom_range(1, 3))};
      13: begin
        s = kw;
        s.putc(0, s[0] - 8'd32);
      end
      14: s = {rand_run(Letters, $urandom_range(1, 2)), rand_run("<>=;()", 1),
                rand_run(Digits, $urandom_range(1, 2))};
      default: begin
        if ($urandom_range(0, 1) != 0) s = one_char(8'($urandom_range(128, 255)));
        else s = rand_run(Strays, 1);
      end
    endcase
    return s;
  endfunction

  task automatic send_request(input logic cmd, input logic [7:0] c);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.ch    <= c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(1'b0, s[i]);
  endtask

  task automatic send_lexeme();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_request(1'b1, 8'($urandom_range(0, 255)));
    end else if (pick < 16) begin
      send_request(1'b0, 8'($urandom_range(0, 255)));
    end else begin
      send_text(random_word());
      pick = $urandom_range(0, 9);
      if (pick < 4) send_request(1'b0, " ");
      else if (pick < 6) send_request(1'b0, "\n");
    end
  endtask

  task automatic drain_sender();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.tokens_due.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random back-pressure plus the requested long hold-off
  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req != 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall == 0 && rx_stalls_on) begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_token(out_ch.token_kind, out_ch.keyword_index, out_ch.token_length,
                       out_ch.last);
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.cmd, in_ch.ch);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_end;
    rst_ni      <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= 1'b0;
    in_ch.ch    <= '0;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_req  = 0;
    items_sent   = 0;
    idle_cycles  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // flush with nothing pending, byte extremes, then the special cases back to back
    send_request(1'b1, 8'h00);
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'hff);
    send_text("while 0x 09 0xg1<>x>=<;1a");
    send_request(1'b1, 8'hff);
    drain_sender();

    for (int phase = 0; items_sent < ItemTarget; phase++) begin
      tx_gaps_on   = (phase % 2) == 1;
      rx_stalls_on = ((phase / 2) % 2) == 1;
      if (phase == 2) rx_hold_req = HoldCycles;
      if (phase == 3) begin
        send_text({"begin", rand_run(Alnum, 260)});
        send_request(1'b0, " ");
        send_text({"9", rand_run(Digits, 258)});
        send_request(1'b1, 8'h00);
      end
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) send_lexeme();
      if (phase % 3 == 2) drain_sender();
    end

    send_request(1'b1, 8'h00);
    drain_sender();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.err_count == 0 && sb.tokens_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/lts_pkg.sv
sv/lts_in_if.sv
sv/lts_out_if.sv
sv/lexical_token_scanner_top.sv
test/lexical_token_scanner_top_test.sv
